// ----- hw/rtl/stsip_pkg.sv -----
// Shared types and constants for the sorted table search block.
package stsip_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int N_CELLS     = ADDR_W + 1;
    localparam int KEY_W       = 32;
    localparam int POS_W       = 9;
    localparam int PADDR_W     = 3;

    // request kinds
    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_SEARCH = 1'b1;

    // register word index (paddr[2])
    localparam logic REG_ENTRY_COUNT = 1'b0;

    typedef struct packed {
        logic             req_type;
        logic [7:0]       entry_index;
        logic [KEY_W-1:0] entry_value;
        logic [KEY_W-1:0] search_key;
    } t_req;

    typedef struct packed {
        logic [POS_W-1:0] position;
        logic             found;
    } t_res;

    // search state handed from cell to cell; hi1 is high+1
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [CNT_W-1:0] low;
        logic [CNT_W-1:0] hi1;
        logic             done;
        logic             found;
    } t_tok;

    // table read request from a cell
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } t_rd_req;

endpackage

// ----- hw/rtl/sorted_table_search_insert_pos.sv -----
// Top level: sorted key table with a chained binary search.
//  - Requests: a transaction is taken at a clock edge with start high and busy
//    low. req_type write stores entry_value at entry_index in the same edge
//    and gives no result; busy stays low, so a new transaction may follow in
//    the next cycle.
//  - req_type search raises busy and runs a binary search over the first
//    entry_count entries (saturated at the table depth). The result (index
//    of a match with found=1, else the insertion point with found=0) shows
//    on o_res for exactly one cycle with o_strobe high. The receiver cannot
//    stall; the result is taken in that cycle.
//  - The search walks a row of ADDR_W+1 probe cells. A cell passes a finished
//    search straight on; when it probes, it issues a table read and then
//    compares the registered read data with the key. All cells share the
//    single read port of the key table, and one search is in flight at a time.
//    busy drops in the strobe cycle, so the next search can be taken there.
//  - entry_count is written over the APB port at byte address 0; pready is
//    always high. Write it only while the block is idle; the block does not enforce it.
//  - Reset clears entry_count and all control state; the table contents are
//    undefined until written.
module sorted_table_search_insert_pos
    import stsip_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // request channel
    input  logic               start,
    output logic               busy,
    input  t_req               i_req,
    // result channel
    output logic               o_strobe,
    output t_res               o_res,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [KEY_W-1:0] r_mem [TABLE_DEPTH];
    logic [KEY_W-1:0] r_rdata;
    logic [CNT_W-1:0] r_entry_count;
    logic             r_busy;
    logic             r_strobe;
    t_res             r_res;

    logic             accept;
    logic             wr_en;
    logic             srch_en;
    logic             cfg_wr;
    logic [CNT_W-1:0] hi1_init;

    // chain links: index i feeds cell i, index N_CELLS leaves the last cell
    logic             tok_vld [N_CELLS+1];
    t_tok             tok     [N_CELLS+1];
    t_rd_req          rd_req  [N_CELLS];
    logic [ADDR_W-1:0] rd_addr;

    assign accept  = start && !r_busy;
    assign wr_en   = accept && (i_req.req_type == REQ_WRITE);
    assign srch_en = accept && (i_req.req_type == REQ_SEARCH);
    assign busy    = r_busy;

    // APB: one register, zero wait states
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_ENTRY_COUNT);
    assign prdata = (paddr[2] == REG_ENTRY_COUNT) ?
                    {{(32-CNT_W){1'b0}}, r_entry_count} : 32'd0;

    // search range is [0, min(count, depth))
    assign hi1_init = (r_entry_count > CNT_W'(TABLE_DEPTH)) ?
                      CNT_W'(TABLE_DEPTH) : r_entry_count;

    always_comb begin
        tok_vld[0]   = srch_en;
        tok[0].key   = i_req.search_key;
        tok[0].low   = '0;
        tok[0].hi1   = hi1_init;
        tok[0].done  = 1'b0;
        tok[0].found = 1'b0;
    end

    for (genvar g = 0; g < N_CELLS; g++) begin : g_cell
        stsip_probe_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_tok_vld (tok_vld[g]),
            .i_tok     (tok[g]),
            .i_rdata   (r_rdata),
            .o_rd      (rd_req[g]),
            .o_tok_vld (tok_vld[g+1]),
            .o_tok     (tok[g+1])
        );
    end

    // at most one cell probes at a time; idle cells drive a zero address
    always_comb begin
        rd_addr = '0;
        for (int i = 0; i < N_CELLS; i++) begin
            rd_addr = rd_addr | rd_req[i].addr;
        end
    end

    // key table, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[i_req.entry_index[ADDR_W-1:0]] <= i_req.entry_value;
        end
        r_rdata <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= '0;
            r_busy        <= 1'b0;
            r_strobe      <= 1'b0;
        end else begin
            if (cfg_wr) begin
                r_entry_count <= pwdata[CNT_W-1:0];
            end
            if (srch_en) begin
                r_busy <= 1'b1;
            end else if (tok_vld[N_CELLS]) begin
                r_busy <= 1'b0;
            end
            r_strobe <= tok_vld[N_CELLS];
        end
        if (tok_vld[N_CELLS]) begin
            // the final low is the match index or the insertion point
            r_res.position <= POS_W'(tok[N_CELLS].low);
            r_res.found    <= tok[N_CELLS].found;
        end
    end

    assign o_strobe = r_strobe;
    assign o_res    = r_res;

endmodule

// ----- hw/rtl/stsip_probe_cell.sv -----
// One probe cell: issues a table read at the midpoint and narrows the range, or passes a finished search on.
module stsip_probe_cell
    import stsip_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_tok_vld,
    input  t_tok             i_tok,
    input  logic [KEY_W-1:0] i_rdata,
    output t_rd_req          o_rd,
    output logic             o_tok_vld,
    output t_tok             o_tok
);

    logic              r_act;
    logic              r_wait;
    t_tok              r_tok;
    logic              n_act;
    logic              n_wait;

    logic [CNT_W-1:0]  diff;
    logic [CNT_W-1:0]  mid_full;
    logic [ADDR_W-1:0] mid;
    logic [CNT_W-1:0]  mid_ext;
    logic              probe_ok;

    assign diff     = r_tok.hi1 - CNT_W'(1) - r_tok.low;
    assign mid_full = r_tok.low + (diff >> 1);
    assign mid      = mid_full[ADDR_W-1:0];
    assign mid_ext  = {1'b0, mid};
    assign probe_ok = !r_tok.done && (r_tok.low < r_tok.hi1);

    always_comb begin
        o_rd.en   = r_act && !r_wait && probe_ok;
        o_rd.addr = o_rd.en ? mid : '0;
        o_tok_vld = 1'b0;
        o_tok     = r_tok;
        if (r_act && !r_wait && !probe_ok) begin
            o_tok_vld  = 1'b1;
            o_tok.done = 1'b1;
        end else if (r_act && r_wait) begin
            o_tok_vld = 1'b1;
            if (i_rdata == r_tok.key) begin
                o_tok.low   = mid_ext;
                o_tok.done  = 1'b1;
                o_tok.found = 1'b1;
            end else if (i_rdata < r_tok.key) begin
                o_tok.low = mid_ext + CNT_W'(1);
            end else begin
                o_tok.hi1 = mid_ext;
            end
        end
    end

    always_comb begin
        n_act  = r_act;
        n_wait = r_wait;
        if (i_tok_vld) begin
            n_act  = 1'b1;
            n_wait = 1'b0;
        end else if (o_tok_vld) begin
            n_act  = 1'b0;
            n_wait = 1'b0;
        end else if (o_rd.en) begin
            n_wait = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act  <= 1'b0;
            r_wait <= 1'b0;
        end else begin
            r_act  <= n_act;
            r_wait <= n_wait;
        end
        if (i_tok_vld) begin
            r_tok <= i_tok;
        end
    end

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the sorted table search block: table writes, searches, APB count.
module tb_top
    import stsip_pkg::*;
();

    // ------------------------------------------------------------------
    // Run constants
    // ------------------------------------------------------------------
    // A search and the longest sender gap both end far inside the watchdog
    // limit, so reaching that many quiet cycles means the block is stuck.
    localparam int WATCHDOG_LIMIT = 1000;
    // Quiet cycles before an APB write and at the end of the run; longer
    // than the slowest search.
    localparam int SETTLE_CYCLES  = 24;
    localparam int MAX_GAP        = 24;

    localparam logic [PADDR_W-1:0] ADDR_ENTRY_COUNT = {REG_ENTRY_COUNT, 2'b00};
    localparam logic [KEY_W-1:0]   KEY_MAX          = {KEY_W{1'b1}};

    // How a table load lays out its keys.
    typedef enum int {
        SHAPE_SORTED,
        SHAPE_DUPLICATES,
        SHAPE_SCRAMBLED
    } t_table_shape;

    // A search waiting for its result, with the key kept for messages.
    typedef struct {
        t_res             res;
        logic [KEY_W-1:0] key;
    } t_pending_search;

    // ------------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // ------------------------------------------------------------------
    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start   = 1'b0;
    logic               busy;
    t_req               i_req   = '0;
    logic               o_strobe;
    t_res               o_res;
    logic               psel    = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite  = 1'b0;
    logic [PADDR_W-1:0] paddr   = '0;
    logic [31:0]        pwdata  = '0;
    logic [31:0]        prdata;
    logic               pready;

    // ------------------------------------------------------------------
    // Shadow copy of the block: key table, entry_count, pending searches
    // ------------------------------------------------------------------
    logic [KEY_W-1:0] shadow_keys [TABLE_DEPTH];
    logic [CNT_W-1:0] shadow_count = '0;
    t_pending_search  pending_searches [$];
    t_pending_search  oldest_search;

    // Bookkeeping
    int err_count   = 0;
    int n_searches  = 0;
    int n_writes    = 0;
    int n_hits      = 0;
    int n_cfg       = 0;
    int idle_pct    = 0;
    int idle_cycles = 0;

    // ------------------------------------------------------------------
    // Clock and DUT
    // ------------------------------------------------------------------
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    sorted_table_search_insert_pos i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_req    (i_req),
        .o_strobe (o_strobe),
        .o_res    (o_res),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // ------------------------------------------------------------------
    // Mismatch reporting
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        $display("tb_top: MISMATCH at %0t: %s", $time, msg);
        err_count++;
    endtask

    // ------------------------------------------------------------------
    // Search predictor. Probes at low+(high-low)/2 over the first
    // entry_count entries, count saturated at the table depth. On a miss
    // the position is where low stopped, i.e. the insertion point.
    // ------------------------------------------------------------------
    function automatic t_res predict_search(input logic [KEY_W-1:0] key);
        int   lo;
        int   hi;
        int   mid;
        int   span;
        t_res r;
        span = (int'(shadow_count) > TABLE_DEPTH) ? TABLE_DEPTH : int'(shadow_count);
        lo   = 0;
        hi   = span - 1;
        r    = '0;
        while (lo <= hi) begin
            mid = lo + (hi - lo) / 2;
            if (shadow_keys[mid] == key) begin
                r.position = POS_W'(mid);
                r.found    = 1'b1;
                return r;
            end
            if (shadow_keys[mid] < key)
                lo = mid + 1;
            else
                hi = mid - 1;
        end
        r.position = POS_W'(lo);
        r.found    = 1'b0;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Request driver. Holds start until the transaction is taken (start
    // high, busy low at an edge), updates the shadow state at that edge,
    // then maybe idles. With no gap start stays high for the next call, so
    // start never gets two assignments in one step.
    // ------------------------------------------------------------------
    task automatic send_req(input t_req req);
        t_pending_search ps;
        int              gap;
        start <= 1'b1;
        i_req <= req;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        if (req.req_type == REQ_SEARCH) begin
            ps.res = predict_search(req.search_key);
            ps.key = req.search_key;
            pending_searches.push_back(ps);
            n_searches++;
        end else begin
            shadow_keys[req.entry_index] = req.entry_value;
            n_writes++;
        end
        if ($urandom_range(99) < idle_pct) begin
            gap = $urandom_range(1, MAX_GAP);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_search(input logic [KEY_W-1:0] key);
        t_req r;
        r.req_type    = REQ_SEARCH;
        r.entry_index = 8'($urandom);   // ignored by a search; random for toggling
        r.entry_value = $urandom;
        r.search_key  = key;
        send_req(r);
    endtask

    task automatic send_write(input int idx, input logic [KEY_W-1:0] value);
        t_req r;
        r.req_type    = REQ_WRITE;
        r.entry_index = 8'(idx);
        r.entry_value = value;
        r.search_key  = $urandom;       // ignored by a write
        send_req(r);
    endtask

    // Drop start, let pending searches come back, then let the block settle.
    task automatic wait_idle();
        start <= 1'b0;
        while (pending_searches.size() != 0 || busy) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // APB: write entry_count while idle, then read it back
    // ------------------------------------------------------------------
    task automatic write_entry_count(input logic [31:0] value);
        logic [31:0] rd;
        wait_idle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_ENTRY_COUNT;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        shadow_count = value[CNT_W-1:0];
        n_cfg++;
        // back-to-back read: new setup phase with psel still high
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd !== 32'(shadow_count))
            report_mismatch($sformatf("entry_count read back %h, want %h", rd,
                                      32'(shadow_count)));
    endtask

    // ------------------------------------------------------------------
    // Table loads: n entries from index 0. Sorted steps are bounded by the
    // headroom left, so keys never wrap.
    // ------------------------------------------------------------------
    task automatic load_table(input int n, input t_table_shape shape);
        logic [KEY_W-1:0] v;
        logic [KEY_W-1:0] room;
        v = $urandom_range(1, 32'h3FFF_FFFF);
        for (int i = 0; i < n; i++) begin
            if (shape == SHAPE_SCRAMBLED)
                send_write(i, $urandom);
            else
                send_write(i, v);
            room = (KEY_MAX - v) / KEY_W'(n - i);
            if (shape == SHAPE_DUPLICATES && $urandom_range(2) != 0)
                room = '0;
            if (room != '0)
                v = v + $urandom_range(0, room);
        end
    endtask

    // Search key mix: mostly keys in the live range (hits), their
    // neighbors (misses between entries), random keys and the extremes.
    function automatic logic [KEY_W-1:0] pick_key();
        int               span;
        logic [KEY_W-1:0] k;
        span = (int'(shadow_count) > TABLE_DEPTH) ? TABLE_DEPTH : int'(shadow_count);
        k    = $urandom;
        if (span > 0)
            k = shadow_keys[$urandom_range(0, span - 1)];
        case ($urandom_range(9))
            0, 1, 2, 3, 4: ;
            5:       k = k + 1'b1;
            6:       k = k - 1'b1;
            7, 8:    k = $urandom;
            default: k = $urandom_range(1) ? KEY_MAX : '0;
        endcase
        return k;
    endfunction

    // ------------------------------------------------------------------
    // Result checker: every strobe is matched against the oldest search
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (pending_searches.size() == 0) begin
                report_mismatch($sformatf("result with no search pending: pos %0d found %0b",
                                          o_res.position, o_res.found));
            end else begin
                oldest_search = pending_searches.pop_front();
                if (o_res.position !== oldest_search.res.position)
                    report_mismatch($sformatf("key %h: position %0d, want %0d",
                                              oldest_search.key, o_res.position,
                                              oldest_search.res.position));
                if (o_res.found !== oldest_search.res.found)
                    report_mismatch($sformatf("key %h: found %b, want %b",
                                              oldest_search.key, o_res.found,
                                              oldest_search.res.found));
                if (o_res.found === 1'b1)
                    n_hits++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: any accepted request, result or APB access resets it
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe || (psel && penable)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top: watchdog expired after %0d quiet cycles", WATCHDOG_LIMIT);
            $display("tb_top: done, errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // After reset entry_count is 0: every search lands at 0, not found,
    // and no table entry is read.
    task automatic test_empty_table();
        send_search('0);
        send_search(KEY_MAX);
        send_search($urandom);
    endtask

    // Fill the whole table in ascending order, so every index is written
    // and later searches never touch an unwritten entry.
    task automatic test_fill_table();
        load_table(TABLE_DEPTH, SHAPE_SORTED);
    endtask

    // Full table: first, last and middle entries, below the first key
    // (position 0), above the last key (position 256), a gap between keys,
    // then a one-entry table.
    task automatic test_directed_search();
        write_entry_count(TABLE_DEPTH);
        send_search(shadow_keys[0]);
        send_search(shadow_keys[TABLE_DEPTH-1]);
        send_search(shadow_keys[TABLE_DEPTH/2]);
        send_search('0);
        send_search(KEY_MAX);
        send_search(shadow_keys[100] + 1'b1);
        write_entry_count(1);
        send_search(shadow_keys[0]);
        send_search('0);
        send_search(KEY_MAX);
    endtask

    // Counts past the table depth are clamped to the depth.
    task automatic test_count_saturation();
        write_entry_count({CNT_W{1'b1}});
        send_search(KEY_MAX);
        send_search(shadow_keys[TABLE_DEPTH-1]);
        write_entry_count(TABLE_DEPTH + 1);
        send_search(shadow_keys[200]);
    endtask

    // Run of equal keys between the key extremes: the hit index follows
    // the probe order. Ends with count 0 written explicitly.
    task automatic test_duplicates_small();
        send_write(0, '0);
        for (int i = 1; i < 5; i++)
            send_write(i, KEY_W'(7));
        send_write(5, KEY_MAX);
        write_entry_count(6);
        send_search(KEY_W'(7));
        send_search('0);
        send_search(KEY_MAX);
        send_search(KEY_W'(8));
        send_search(KEY_W'(6));
        write_entry_count(0);
        send_search(KEY_W'(7));
    endtask

    // One random round: pick a count (mostly small or medium reloaded tables,
    // some zero, large or oversized counts over what is already there), write it,
    // then a burst of searches with the odd stray write mixed in.
    task automatic random_round();
        int            sel;
        int            n;
        int            n_req;
        logic [31:0]   cfg;
        t_table_shape  shape;
        sel   = $urandom_range(99);
        shape = SHAPE_SORTED;
        if ($urandom_range(9) < 2)
            shape = SHAPE_DUPLICATES;
        else if ($urandom_range(9) == 0)
            shape = SHAPE_SCRAMBLED;
        if (sel < 5) begin
            n = 0;
        end else if (sel < 75) begin
            n = $urandom_range(1, 16);
            load_table(n, shape);
        end else if (sel < 88) begin
            n = $urandom_range(17, 64);
            load_table(n, shape);
        end else if (sel < 96) begin
            n = $urandom_range(200, TABLE_DEPTH);
        end else begin
            n = $urandom_range(TABLE_DEPTH + 1, (1 << CNT_W) - 1);
        end
        // upper pwdata bits are don't-care; toggle them now and then
        cfg = 32'(n);
        if ($urandom_range(3) == 0)
            cfg = cfg | ($urandom & ~32'((1 << CNT_W) - 1));
        write_entry_count(cfg);
        n_req = $urandom_range(4, 12);
        for (int i = 0; i < n_req; i++) begin
            if ($urandom_range(9) == 0)
                send_write($urandom_range(0, TABLE_DEPTH - 1), $urandom);
            else
                send_search(pick_key());
        end
    endtask

    task automatic test_random(input int pct, input int n_items);
        int first;
        idle_pct = pct;
        first    = n_searches + n_writes;
        while (n_searches + n_writes - first < n_items)
            random_round();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        idle_pct = 30;
        test_empty_table();
        test_fill_table();
        test_directed_search();
        test_count_saturation();
        test_duplicates_small();

        test_random(30, 190);
        test_random(65, 190);
        test_random(0, 190);

        wait_idle();

        $display("tb_top: %0d searches (%0d found), %0d table writes, %0d entry_count writes",
                 n_searches, n_hits, n_writes, n_cfg);
        $display("tb_top: sender idle at 30%%, 65%% and 0%%; %0d mismatches", err_count);
        if (err_count == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
